// ----- rtl/aarm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation matrix: shared types and constants
// Data records handed between the cells of the square-root, divider and
// CORDIC chains, plus the constant tables used by those chains.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // Fixed pipeline depths of the normalization path and the matrix stages.
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned DIV_STEPS    = 31;
  localparam int unsigned NORM_LAT     = SQRT_STEPS + DIV_STEPS + 3;
  localparam int unsigned MAT_LAT      = 5;
  localparam int unsigned ATAN_ENTRIES = 24;

  // round(2^32 / (2*pi)): radians to a 32-bit turn fraction.
  localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
  // CORDIC gain compensation in Q30.
  localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

  // Arctangents of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Quarter turn that the phase was folded by.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } aarm_quad_e;

  typedef struct packed {
    logic [63:0]      v;
    logic [63:0]      r;
    logic [2:0][15:0] axis;
    logic             zero;
  } aarm_sqrt_t;

  typedef struct packed {
    logic [32:0]      len;
    logic [2:0][32:0] rem;
    logic [2:0][30:0] low;
    logic [2:0][30:0] quo;
    logic [2:0]       neg;
    logic             zero;
  } aarm_div_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    aarm_quad_e         quad;
  } aarm_cordic_t;

  typedef struct packed {
    logic signed [33:0] c;
    logic signed [33:0] s;
  } aarm_sincos_t;

endpackage

// ----- rtl/aarm_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module aarm_sqrt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  aarm_pkg::aarm_sqrt_t cell_i,
  output aarm_pkg::aarm_sqrt_t cell_o
);
  import aarm_pkg::*;

  localparam logic [63:0] BIT = 64'd1 << (2 * (31 - IDX));

  aarm_sqrt_t  cell_d, cell_q;
  logic [64:0] trial;

  always_comb begin
    cell_d = cell_i;
    trial  = {1'b0, cell_i.r} + {1'b0, BIT};
    if ({1'b0, cell_i.v} >= trial) begin
      cell_d.v = cell_i.v - trial[63:0];
      cell_d.r = (cell_i.r >> 1) + BIT;
    end else begin
      cell_d.r = cell_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- rtl/aarm_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division quotient bit for each of the three axis components.
// ----------------------------------------------------------------------------
module aarm_div_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  aarm_pkg::aarm_div_t cell_i,
  output aarm_pkg::aarm_div_t cell_o
);
  import aarm_pkg::*;

  aarm_div_t   cell_d, cell_q;
  logic [33:0] trial [3];
  logic        fit   [3];

  always_comb begin
    cell_d = cell_i;
    for (int i = 0; i < 3; i++) begin
      trial[i] = {cell_i.rem[i], cell_i.low[i][30]};
      fit[i]   = trial[i] >= {1'b0, cell_i.len};
      cell_d.rem[i] = fit[i] ? 33'(trial[i] - {1'b0, cell_i.len}) : trial[i][32:0];
      cell_d.low[i] = {cell_i.low[i][29:0], 1'b0};
      cell_d.quo[i] = {cell_i.quo[i][29:0], fit[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- rtl/aarm_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation by the arctangent of 2^-IDX, registered.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  aarm_pkg::aarm_cordic_t cell_i,
  output aarm_pkg::aarm_cordic_t cell_o
);
  import aarm_pkg::*;

  localparam logic signed [32:0] ATAN = $signed({1'b0, ATAN_TURNS[IDX]});

  aarm_cordic_t       cell_d, cell_q;
  logic signed [33:0] xs, ys;

  always_comb begin
    cell_d = cell_i;
    xs     = cell_i.x >>> IDX;
    ys     = cell_i.y >>> IDX;
    if (!cell_i.z[32]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - ATAN;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- rtl/aarm_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix assembly
// Five-stage pipeline forming (1-cos)*n*n' + cos*I + sin*K in Q30 and
// rounding each entry to the output format.
// ----------------------------------------------------------------------------
module aarm_matrix #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [2:0][31:0]        n_i,
  input  logic signed [33:0]      c_i,
  input  logic signed [33:0]      s_i,
  input  logic                    zero_i,
  output logic [8:0][15:0]        mat_o,
  output logic                    zero_o
);
  import aarm_pkg::*;

  localparam longint ONE_L = 64'sd1 <<< FRAC_BITS;
  localparam longint HI_L  = (ONE_L > 32767) ? 32767 : ONE_L;
  localparam longint LO_L  = (-ONE_L < -32768) ? -32768 : -ONE_L;
  localparam logic signed [35:0] HI   = 36'(HI_L);
  localparam logic signed [35:0] LO   = 36'(LO_L);
  localparam int unsigned        SH   = 30 - FRAC_BITS;
  localparam logic signed [35:0] HALF = 36'sd1 <<< (SH - 1);

  // Stage A: raw products.
  logic signed [63:0] pnn_d [6], pnn_q [6];
  logic signed [65:0] psn_d [3], psn_q [3];
  logic signed [33:0] c_a_q;
  logic               z_a_q;
  // Stage B: rounded products.
  logic signed [31:0] outer_d [6], outer_q [6];
  logic signed [32:0] skp_d [3], skp_q [3], skm_d [3], skm_q [3];
  logic signed [34:0] omc_q;
  logic signed [33:0] c_b_q;
  logic               z_b_q;
  // Stage C: (1-cos) times outer product.
  logic signed [66:0] pom_d [6], pom_q [6];
  logic signed [32:0] skp_c_q [3], skm_c_q [3];
  logic signed [33:0] c_c_q;
  logic               z_c_q;
  // Stage D1: Q30 sums.
  logic signed [35:0] ro [6];
  logic signed [35:0] v_d [9], v_q [9];
  logic               z_d_q;
  // Stage D2: output.
  logic signed [35:0] w [9];
  logic [8:0][15:0]   mat_d, mat_q;
  logic               zero_q;

  logic signed [64:0] t65;
  logic signed [66:0] t67p, t67m;
  logic signed [67:0] t68;

  always_comb begin
    pnn_d[0] = $signed(n_i[0]) * $signed(n_i[0]);
    pnn_d[1] = $signed(n_i[1]) * $signed(n_i[1]);
    pnn_d[2] = $signed(n_i[2]) * $signed(n_i[2]);
    pnn_d[3] = $signed(n_i[0]) * $signed(n_i[1]);
    pnn_d[4] = $signed(n_i[0]) * $signed(n_i[2]);
    pnn_d[5] = $signed(n_i[1]) * $signed(n_i[2]);
    for (int i = 0; i < 3; i++) begin
      psn_d[i] = 66'(s_i) * 66'($signed(n_i[i]));
    end
  end

  always_comb begin
    t65  = '0;
    t67p = '0;
    t67m = '0;
    for (int i = 0; i < 6; i++) begin
      t65        = 65'(pnn_q[i]) + 65'sd536870912;
      outer_d[i] = 32'(t65 >>> 30);
    end
    for (int i = 0; i < 3; i++) begin
      t67p     = 67'(psn_q[i]) + 67'sd536870912;
      t67m     = -67'(psn_q[i]) + 67'sd536870912;
      skp_d[i] = 33'(t67p >>> 30);
      skm_d[i] = 33'(t67m >>> 30);
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pom_d[i] = 67'(omc_q) * 67'(outer_q[i]);
    end
  end

  always_comb begin
    t68 = '0;
    for (int i = 0; i < 6; i++) begin
      t68   = 68'(pom_q[i]) + 68'sd536870912;
      ro[i] = 36'(t68 >>> 30);
    end
    // Column-major entries; the off-diagonal sine terms follow the skew layout
    // K = [0 nz -ny; -nz 0 nx; ny -nx 0].
    v_d[0] = ro[0] + 36'(c_c_q);
    v_d[1] = ro[3] + 36'(skm_c_q[2]);
    v_d[2] = ro[4] + 36'(skp_c_q[1]);
    v_d[3] = ro[3] + 36'(skp_c_q[2]);
    v_d[4] = ro[1] + 36'(c_c_q);
    v_d[5] = ro[5] + 36'(skm_c_q[0]);
    v_d[6] = ro[4] + 36'(skm_c_q[1]);
    v_d[7] = ro[5] + 36'(skp_c_q[0]);
    v_d[8] = ro[2] + 36'(c_c_q);
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      w[e] = (v_q[e] + HALF) >>> SH;
      if (w[e] > HI) begin
        w[e] = HI;
      end
      if (w[e] < LO) begin
        w[e] = LO;
      end
      if (z_d_q) begin
        mat_d[e] = (e % 4 == 0) ? HI[15:0] : 16'd0;
      end else begin
        mat_d[e] = w[e][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnn_q   <= pnn_d;
      psn_q   <= psn_d;
      c_a_q   <= c_i;
      z_a_q   <= zero_i;
      outer_q <= outer_d;
      skp_q   <= skp_d;
      skm_q   <= skm_d;
      omc_q   <= 35'sd1073741824 - 35'(c_a_q);
      c_b_q   <= c_a_q;
      z_b_q   <= z_a_q;
      pom_q   <= pom_d;
      skp_c_q <= skp_q;
      skm_c_q <= skm_q;
      c_c_q   <= c_b_q;
      z_c_q   <= z_b_q;
      v_q     <= v_d;
      z_d_q   <= z_c_q;
      mat_q   <= mat_d;
      zero_q  <= z_d_q;
    end
  end

  assign mat_o  = mat_q;
  assign zero_o = zero_q;

endmodule

// ----- rtl/axis_angle_rotation_matrix_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle to rotation matrix
// Converts an angle and an unnormalized axis into the 3x3 Rodrigues matrix.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one beat per transform: the angle in radians
//   (signed Q4.13) and the three axis components (signed Q1.14, any length).
//   The master channel returns one beat per input beat, in order, holding the
//   nine matrix entries column by column and a flag in tuser that is set when
//   the axis was all zeros, in which case the matrix is the identity.
//   The datapath is one pipeline that takes a beat every cycle unless the
//   output stalls. Latency from an accepted input beat to the output beat is
//   set by the chain of 32 square-root cells and 31 divider cells that
//   normalize the axis plus the five matrix stages; sine and cosine come
//   from a chain of CORDIC_STAGES cells that runs alongside and is delayed to line up.
//   The whole pipeline advances together: when the output holds a beat that
//   the receiver has not taken, every stage holds and s_axis_tready drops in
//   the same cycle, so no beat is lost. Bubbles travel as invalid stages.
//   Reset clears only the stage valid bits; the payload registers need none.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // angle [17:0], axis_x [33:18], axis_y [49:34], axis_z [65:50], zero fill
  input  logic [71:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // m_r0_c0, m_r1_c0, m_r2_c0, m_r0_c1, m_r1_c1, m_r2_c1, m_r0_c2, m_r1_c2,
  // m_r2_c2, 16 bits each from bit 0 up
  output logic [143:0]  m_axis_tdata,
  // zero_axis [0]
  output logic          m_axis_tuser
);
  import aarm_pkg::*;

  localparam int unsigned LAT = NORM_LAT + MAT_LAT;
  // Delay that lines sine and cosine up with the normalized axis.
  localparam int unsigned DLY = NORM_LAT - CORDIC_STAGES - 3;

  logic           adv;
  logic [LAT-1:0] valid_q;

  // Input fields.
  logic signed [17:0] angle;
  logic [2:0][15:0]   axis;

  assign angle   = $signed(s_axis_tdata[17:0]);
  assign axis[0] = s_axis_tdata[33:18];
  assign axis[1] = s_axis_tdata[49:34];
  assign axis[2] = s_axis_tdata[65:50];

  // The pipeline moves whenever the output register is free or being taken.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Normalization path: squared length, square-root chain, divider chain.
  // --------------------------------------------------------------------------
  aarm_sqrt_t sqrt_chain [SQRT_STEPS+1];
  aarm_sqrt_t sqrt_d, sqrt_q;
  logic [31:0] len2;

  always_comb begin
    len2 = 32'($signed(axis[0]) * $signed(axis[0]))
         + 32'($signed(axis[1]) * $signed(axis[1]))
         + 32'($signed(axis[2]) * $signed(axis[2]));
    sqrt_d.v    = {len2, 32'd0};
    sqrt_d.r    = '0;
    sqrt_d.axis = axis;
    sqrt_d.zero = (len2 == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqrt_q <= sqrt_d;
    end
  end

  assign sqrt_chain[0] = sqrt_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    aarm_sqrt_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .cell_i (sqrt_chain[k]),
      .cell_o (sqrt_chain[k+1])
    );
  end

  // Numerator (|a| * 2^46 + len/2) split into the initial remainder and the
  // bits still to be shifted in.
  aarm_sqrt_t  sq_end;
  aarm_div_t   div_d, div_q;
  aarm_div_t   div_chain [DIV_STEPS+1];
  logic [15:0] mag [3];
  logic [61:0] numer [3];

  assign sq_end = sqrt_chain[SQRT_STEPS];

  always_comb begin
    div_d.len  = sq_end.r[32:0];
    div_d.zero = sq_end.zero;
    div_d.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i]        = sq_end.axis[i][15] ? 16'(-sq_end.axis[i]) : sq_end.axis[i];
      numer[i]      = {mag[i], 46'd0} + {29'd0, sq_end.r[32:1]};
      div_d.rem[i]  = {2'b00, numer[i][61:31]};
      div_d.low[i]  = numer[i][30:0];
      div_d.neg[i]  = sq_end.axis[i][15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q <= div_d;
    end
  end

  assign div_chain[0] = div_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    aarm_div_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .cell_i (div_chain[k]),
      .cell_o (div_chain[k+1])
    );
  end

  // Restore the component signs.
  aarm_div_t        dv_end;
  logic [2:0][31:0] n_d, n_q;
  logic             zero_q;

  assign dv_end = div_chain[DIV_STEPS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = dv_end.neg[i] ? -{1'b0, dv_end.quo[i]} : {1'b0, dv_end.quo[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q    <= n_d;
      zero_q <= dv_end.zero;
    end
  end

  // --------------------------------------------------------------------------
  // Sine and cosine: phase, quarter-turn fold, CORDIC chain, quadrant fix-up.
  // --------------------------------------------------------------------------
  logic signed [48:0] prod;
  logic [31:0]        phase_q;
  logic [31:0]        fold_sum, resid;
  aarm_cordic_t       cor_d, cor_q;
  aarm_cordic_t       cor_chain [CORDIC_STAGES+1];

  assign prod = 49'(angle) * $signed({19'd0, TURN_PER_RAD});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      phase_q <= prod[44:13];
    end
  end

  always_comb begin
    fold_sum   = phase_q + 32'h2000_0000;
    resid      = phase_q - {fold_sum[31:30], 30'd0};
    cor_d.x    = CORDIC_X0;
    cor_d.y    = '0;
    cor_d.z    = $signed({resid[31], resid});
    cor_d.quad = aarm_quad_e'(fold_sum[31:30]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cor_q <= cor_d;
    end
  end

  assign cor_chain[0] = cor_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    aarm_cordic_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .cell_i (cor_chain[k]),
      .cell_o (cor_chain[k+1])
    );
  end

  aarm_cordic_t cor_end;
  aarm_sincos_t sc_d;
  aarm_sincos_t sc_dly_q [DLY+1];

  assign cor_end = cor_chain[CORDIC_STAGES];

  always_comb begin
    case (cor_end.quad)
      QUAD_0: begin
        sc_d.c = cor_end.x;
        sc_d.s = cor_end.y;
      end
      QUAD_1: begin
        sc_d.c = -cor_end.y;
        sc_d.s = cor_end.x;
      end
      QUAD_2: begin
        sc_d.c = -cor_end.x;
        sc_d.s = -cor_end.y;
      end
      default: begin
        sc_d.c = cor_end.y;
        sc_d.s = -cor_end.x;
      end
    endcase
  end

  // Slot 0 is the quadrant register; the rest is the alignment delay.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_dly_q[0] <= sc_d;
      for (int k = 1; k <= DLY; k++) begin
        sc_dly_q[k] <= sc_dly_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Matrix assembly and output register.
  // --------------------------------------------------------------------------
  logic [8:0][15:0] mat;
  logic             mat_zero;

  aarm_matrix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .en_i   (adv),
    .n_i    (n_q),
    .c_i    (sc_dly_q[DLY].c),
    .s_i    (sc_dly_q[DLY].s),
    .zero_i (zero_q),
    .mat_o  (mat),
    .zero_o (mat_zero)
  );

  assign m_axis_tdata = mat;
  assign m_axis_tuser = mat_zero;

endmodule
